### hw/rtl/channel_average_threshold_scan_macros.svh
// Assertion macros used by the channel average threshold scan sequencer
`ifndef CHANNEL_AVERAGE_THRESHOLD_SCAN_MACROS_SVH
`define CHANNEL_AVERAGE_THRESHOLD_SCAN_MACROS_SVH

// Check a property on every clock edge outside reset
`define CATS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define CATS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle
`define CATS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/cats_pkg.sv
// Types and constants for the channel average threshold scan block
package cats_pkg;

  localparam int unsigned AVG_W  = 16;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned KIND_W = 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_LIMIT    = 1'd1;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_SCAN   = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_AVERAGE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SELECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY  = 2'd2;

  // Selections reported per scan saturate here
  localparam logic [CNT_W-1:0] MAX_SELECT = 4'd15;

  typedef struct packed {
    logic              req_type;
    logic [CHAN_W-1:0] channel;
    logic [AVG_W-1:0]  sample;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] chan_index;
    logic [AVG_W-1:0]  average;
    logic [CNT_W-1:0]  selected_count;
    logic              aborted;
    logic              last;
  } out_word_t;

endpackage

### hw/rtl/cats_avg_mem.sv
// Per-channel average memory with registered read and per-entry valid bits
module cats_avg_mem import cats_pkg::*; #(
  parameter int unsigned DEPTH = 15,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [AVG_W-1:0] wdata_i,
  output logic [AVG_W-1:0] rdata_o
);

  logic [AVG_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [AVG_W-1:0] rdata_q;
  logic             rvalid_q;

  // Write the array and register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // An entry never written reads as zero
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### hw/rtl/cats_ctrl.sv
// Sequencer for sample updates and threshold scans, with the output register
`include "channel_average_threshold_scan_macros.svh"

module cats_ctrl import cats_pkg::*; #(
  parameter int unsigned CHANNELS = 15,
  parameter int unsigned SHIFT    = 8,
  parameter int unsigned AW       = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [AVG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  output logic                 mem_re_o,
  output logic [AW-1:0]        mem_raddr_o,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output logic [AVG_W-1:0]     mem_wdata_o,
  input  logic [AVG_W-1:0]     mem_rdata_i
);

  localparam int unsigned CW   = (AW > CHAN_W) ? AW : CHAN_W;
  localparam int unsigned SW   = AVG_W + SHIFT + 1;
  localparam logic [6:0]  LIM  = 7'(CHANNELS);
  localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_ABT  = 3'd2;
  localparam logic [2:0] ST_SEL  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             abort_q, abort_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [AVG_W-1:0] smp_q, smp_d;
  logic [AVG_W-1:0] dry_q, safe_q;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;
  logic             out_load;
  logic             can_load;
  logic             in_acc;
  logic [CW-1:0]    ch_ext;
  logic [CW-1:0]    idx_ext;
  logic [CW-1:0]    addr_ext;
  logic             ch_ok;
  logic [SW-1:0]    acc;
  logic [AVG_W-1:0] next_avg;
  logic             sel;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q  <= '0;
      safe_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DRY_THRESHOLD: dry_q  <= cfg_data_i;
        CFG_SAFE_LIMIT:    safe_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Address and channel conversions
  assign ch_ext   = CW'(in_word_i.channel);
  assign idx_ext  = CW'(idx_q);
  assign addr_ext = CW'(addr_q);
  assign ch_ok    = {3'b000, in_word_i.channel} < LIM;

  // Average update: avg * (2^SHIFT - 1) + sample, then shift down
  assign acc      = (SW'(mem_rdata_i) << SHIFT) - SW'(mem_rdata_i) + SW'(smp_q);
  assign next_avg = acc[SHIFT +: AVG_W];

  assign sel      = (mem_rdata_i < dry_q) && (cnt_q != MAX_SELECT);
  assign can_load = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;

  // Sequence the memory accesses and result words
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    abort_d     = abort_q;
    addr_d      = addr_q;
    smp_d       = smp_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_q;
    mem_wdata_o = next_avg;
    out_load    = 1'b0;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word_i.req_type == REQ_SCAN) begin
            mem_re_o = 1'b1;
            idx_d    = '0;
            cnt_d    = '0;
            abort_d  = 1'b0;
            state_d  = ST_ABT;
          end else if (ch_ok) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = ch_ext[AW-1:0];
            addr_d      = ch_ext[AW-1:0];
            smp_d       = in_word_i.sample;
            state_d     = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        if (can_load) begin
          mem_we_o = 1'b1;
          out_load = 1'b1;
          out_d    = '{kind: KIND_AVERAGE, chan_index: addr_ext[CHAN_W-1:0],
                       average: next_avg, selected_count: '0, aborted: 1'b0,
                       last: 1'b1};
          state_d  = ST_IDLE;
        end
      end
      ST_ABT: begin
        if (mem_rdata_i >= safe_q) begin
          abort_d = 1'b1;
          state_d = ST_SUM;
        end else if (idx_q == LAST_IDX) begin
          mem_re_o = 1'b1;
          idx_d    = '0;
          state_d  = ST_SEL;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + 1'b1;
          idx_d       = idx_q + 1'b1;
        end
      end
      ST_SEL: begin
        if (!sel || can_load) begin
          if (sel) begin
            out_load = 1'b1;
            out_d    = '{kind: KIND_SELECTED, chan_index: idx_ext[CHAN_W-1:0],
                         average: mem_rdata_i, selected_count: '0, aborted: 1'b0,
                         last: 1'b0};
            cnt_d    = cnt_q + 1'b1;
          end
          if (idx_q == LAST_IDX) begin
            state_d = ST_SUM;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_q + 1'b1;
            idx_d       = idx_q + 1'b1;
          end
        end
      end
      ST_SUM: begin
        if (can_load) begin
          out_load = 1'b1;
          out_d    = '{kind: KIND_SUMMARY, chan_index: '0, average: '0,
                       selected_count: abort_q ? '0 : cnt_q, aborted: abort_q,
                       last: 1'b1};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result word until the receiver takes it
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      abort_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      abort_q     <= abort_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    smp_q  <= smp_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `CATS_ASSERT(a_no_rd_wr_overlap, !(mem_we_o && mem_re_o), "memory read and write overlap")
  `CATS_ASSERT_NXT(a_wr_ends_item, mem_we_o, state_q == ST_IDLE, "write did not end the item")
  `CATS_ASSERT_IMP(a_abort_no_count, out_load && out_d.aborted, out_d.selected_count == '0,
                   "aborted summary carries a count")
  `CATS_ASSERT_IMP(a_load_has_room, out_load, !out_valid_q || !out_stall_i,
                   "result word overwritten while stalled")

endmodule

### hw/rtl/channel_average_threshold_scan.sv
// Top level of the per-channel moving average and threshold scan block
//
// Input channel: in_valid_i / in_stall_o carry one in_word_t word. A sample
// word updates its channel's average as (avg*(2^SHIFT-1) + sample) >> SHIFT
// and returns one word with the new average; a sample for a channel at or
// beyond CHANNELS is taken and dropped. A scan word returns a single aborted
// summary if any average is at or above safe_limit, else one word per channel
// below dry_threshold (at most 15) and then a summary with the count.
// Output channel: out_valid_o / out_stall_i, one out_word_t word per result,
// last set on the final word of each input word.
// Sequence: a sample is accepted with its memory read, then written back
// and loaded into the output register; a scan is accepted, reads every
// channel in an abort pass and then in a selection pass, and loads the
// summary. The sequencer makes one memory read per cycle while not stalled
// and takes no new input word until it is back in idle.
// Reset clears the averages (through per-entry valid bits) and both
// thresholds at once. While the receiver stalls, the output register holds
// its word, the sequencer waits before each load, and one item may be accepted.
module channel_average_threshold_scan import cats_pkg::*; #(
  parameter int unsigned CHANNELS = 15,
  parameter int unsigned SHIFT    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [AVG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AVG_W-1:0] mem_wdata;
  logic [AVG_W-1:0] mem_rdata;

  // Average store
  cats_avg_mem #(
    .DEPTH(CHANNELS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Sequencer and output register
  cats_ctrl #(
    .CHANNELS(CHANNELS),
    .SHIFT   (SHIFT),
    .AW      (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

endmodule

### verif/channel_average_threshold_scan_tb.sv
// Self-checking testbench for the per-channel moving average and threshold scan block
`timescale 1ns / 1ps

module channel_average_threshold_scan_tb;
  import cats_pkg::*;

  localparam int unsigned NUM_CH      = 15;
  localparam int unsigned AVG_SHIFT   = 8;
  // a scan walks the channels twice; allow a margin on top
  localparam int unsigned SETTLE_CYCS = 2 * NUM_CH + 10;
  localparam int unsigned PHASE_WORDS = 58;
  localparam int unsigned NUM_PHASES  = 6;

  // Tracks the channel averages and thresholds, and queues the words each request should give
  class avg_scan_board;
    logic [AVG_W-1:0] chan_avg [NUM_CH];
    logic [AVG_W-1:0] dry_level;
    logic [AVG_W-1:0] safe_level;
    out_word_t        awaited_words [$];
    int unsigned      mismatches;

    function new();
      foreach (chan_avg[i]) chan_avg[i] = '0;
      dry_level  = '0;
      safe_level = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [AVG_W-1:0] data);
      if (idx == CFG_DRY_THRESHOLD) dry_level = data;
      else if (idx == CFG_SAFE_LIMIT) safe_level = data;
    endfunction

    function logic [AVG_W-1:0] top_avg();
      logic [AVG_W-1:0] m;
      m = '0;
      foreach (chan_avg[i]) if (chan_avg[i] > m) m = chan_avg[i];
      return m;
    endfunction

    function logic [AVG_W-1:0] bottom_avg();
      logic [AVG_W-1:0] m;
      m = '1;
      foreach (chan_avg[i]) if (chan_avg[i] < m) m = chan_avg[i];
      return m;
    endfunction

    // Work out the result words of one accepted request word
    function void note_input(in_word_t w);
      out_word_t   r;
      logic [31:0] acc;
      int unsigned picked;
      bit          tripped;
      picked  = 0;
      tripped = 1'b0;
      if (w.req_type == REQ_SAMPLE) begin
        // drop samples for channels beyond the last one
        if (w.channel < NUM_CH) begin
          acc = ({16'd0, chan_avg[w.channel]} << AVG_SHIFT) - chan_avg[w.channel] + w.sample;
          acc = acc >> AVG_SHIFT;
          chan_avg[w.channel] = acc[AVG_W-1:0];
          r = '0;
          r.kind       = KIND_AVERAGE;
          r.chan_index = w.channel;
          r.average    = acc[AVG_W-1:0];
          r.last       = 1'b1;
          awaited_words.push_back(r);
        end
      end else begin
        foreach (chan_avg[i]) if (chan_avg[i] >= safe_level) tripped = 1'b1;
        if (tripped) begin
          r = '0;
          r.kind    = KIND_SUMMARY;
          r.aborted = 1'b1;
          r.last    = 1'b1;
          awaited_words.push_back(r);
        end else begin
          foreach (chan_avg[i]) begin
            if (chan_avg[i] < dry_level && picked < MAX_SELECT) begin
              r = '0;
              r.kind       = KIND_SELECTED;
              r.chan_index = CHAN_W'(i);
              r.average    = chan_avg[i];
              awaited_words.push_back(r);
              picked++;
            end
          end
          r = '0;
          r.kind           = KIND_SUMMARY;
          r.selected_count = CNT_W'(picked);
          r.last           = 1'b1;
          awaited_words.push_back(r);
        end
      end
    endfunction

    function void report(string what, out_word_t want, out_word_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s", $realtime, what);
        $display("  expected kind=%0d ch=%0d avg=%0d cnt=%0d abort=%0b last=%0b",
                 want.kind, want.chan_index, want.average, want.selected_count,
                 want.aborted, want.last);
        $display("  actual   kind=%0d ch=%0d avg=%0d cnt=%0d abort=%0b last=%0b",
                 got.kind, got.chan_index, got.average, got.selected_count,
                 got.aborted, got.last);
      end
    endfunction

    // Compare one accepted result word with the oldest awaited one
    function void check_result(out_word_t got);
      out_word_t want;
      if (awaited_words.size() == 0) begin
        report("result word with none awaited", '0, got);
      end else begin
        want = awaited_words.pop_front();
        if (got.kind != want.kind || got.chan_index != want.chan_index ||
            got.average != want.average || got.selected_count != want.selected_count ||
            got.aborted != want.aborted || got.last != want.last)
          report("result word mismatch", want, got);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_DRY_THRESHOLD;
  logic [AVG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;

  bit                   quiet = 1'b0;
  avg_scan_board        board = new();

  channel_average_threshold_scan #(
    .CHANNELS(NUM_CH),
    .SHIFT   (AVG_SHIFT)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always #5 clk = ~clk;

  // Take result words and stall the output at random outside the quiet stretch
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_word);
    out_stall <= !quiet && ($urandom_range(99) < 20);
  end

  function automatic in_word_t word_of(logic req, logic [CHAN_W-1:0] ch, logic [AVG_W-1:0] smp);
    in_word_t w;
    w.req_type = req;
    w.channel  = ch;
    w.sample   = smp;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.req_type = ($urandom_range(99) < 18) ? REQ_SCAN : REQ_SAMPLE;
    w.channel  = ($urandom_range(99) < 6) ? CHAN_W'(NUM_CH) : CHAN_W'($urandom_range(NUM_CH - 1));
    case ($urandom_range(7))
      0:       w.sample = '0;
      1:       w.sample = '1;
      default: w.sample = AVG_W'($urandom);
    endcase
    return w;
  endfunction

  function automatic logic [AVG_W-1:0] sat16(int unsigned v);
    return (v > 65535) ? 16'hFFFF : AVG_W'(v);
  endfunction

  // Offer one request word, with an occasional idle gap first; valid stays high on return
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (!quiet && $urandom_range(99) < 20) begin
      gap = $urandom_range(16, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    board.note_input(w);
  endtask

  // Wait for every awaited word, then let a dropped word or a scan run out
  task automatic wait_idle();
    while (board.awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCS) @(posedge clk);
  endtask

  task automatic set_levels(input logic [AVG_W-1:0] dry, input logic [AVG_W-1:0] safe);
    in_valid <= 1'b0;
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_DRY_THRESHOLD;
    cfg_data <= dry;
    @(posedge clk);
    board.set_reg(CFG_DRY_THRESHOLD, dry);
    cfg_idx  <= CFG_SAFE_LIMIT;
    cfg_data <= safe;
    @(posedge clk);
    board.set_reg(CFG_SAFE_LIMIT, safe);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic [AVG_W-1:0] hi;
    logic [AVG_W-1:0] lo;
    logic [AVG_W-1:0] dry;
    logic [AVG_W-1:0] safe;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Thresholds at reset: every scan aborts
    send_word(word_of(REQ_SCAN, 4'd0, 16'h0000));
    send_word(word_of(REQ_SAMPLE, 4'd0, 16'hFFFF));
    send_word(word_of(REQ_SAMPLE, 4'd0, 16'hFFFF));
    send_word(word_of(REQ_SAMPLE, 4'd14, 16'h0000));
    send_word(word_of(REQ_SAMPLE, 4'd14, 16'hFFFF));
    send_word(word_of(REQ_SAMPLE, 4'd7, 16'hAAAA));
    send_word(word_of(REQ_SAMPLE, 4'd8, 16'h5555));
    // out-of-range channel is dropped
    send_word(word_of(REQ_SAMPLE, 4'd15, 16'hFFFF));
    send_word(word_of(REQ_SAMPLE, 4'd15, 16'h0000));
    send_word(word_of(REQ_SCAN, 4'd15, 16'hFFFF));

    // Every channel selected: the count reaches its limit
    set_levels(16'hFFFF, 16'hFFFF);
    send_word(word_of(REQ_SCAN, 4'd0, 16'h0000));
    // Nothing selected
    set_levels(16'h0000, 16'hFFFF);
    send_word(word_of(REQ_SCAN, 4'd0, 16'h0000));
    // An average exactly at the safe limit aborts
    set_levels(16'h0001, board.top_avg());
    send_word(word_of(REQ_SCAN, 4'd0, 16'h0000));
    send_word(word_of(REQ_SAMPLE, 4'd3, 16'h1234));

    // Random phases, each under its own thresholds drawn around the present averages
    for (int p = 0; p < NUM_PHASES; p++) begin
      hi = board.top_avg();
      lo = board.bottom_avg();
      case (p)
        0: begin
          dry  = sat16($urandom_range(int'(hi) + 1, int'(lo)));
          safe = sat16(int'(hi) + $urandom_range(3000, 1));
        end
        1: begin
          dry  = sat16(int'(hi) + 1);
          safe = sat16(int'(hi) + $urandom_range(600, 200));
        end
        2: begin
          dry  = AVG_W'((int'(lo) + int'(hi)) / 2);
          safe = 16'hFFFF;
        end
        3: begin
          dry  = AVG_W'($urandom);
          safe = 16'h0000;
        end
        4: begin
          dry  = AVG_W'($urandom);
          safe = sat16(int'(hi) + $urandom_range(800));
        end
        default: begin
          dry  = sat16($urandom_range(int'(hi) + 1, int'(lo)));
          safe = sat16(int'(hi) + $urandom_range(1500, 1));
        end
      endcase
      set_levels(dry, safe);
      // run one phase with no idling on either side
      quiet = (p == 2);
      repeat (PHASE_WORDS) send_word(random_word());
    end

    in_valid <= 1'b0;
    wait_idle();
    if (board.mismatches == 0) begin
      $display("channel_average_threshold_scan_tb: done, clean");
    end else begin
      $display("channel_average_threshold_scan_tb: done, errors");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #5_000_000;
    $display("channel_average_threshold_scan_tb: done, errors");
    $finish;
  end

endmodule
